FILE: hdl/ndr_pkg.sv
// Shared constants and helpers for the NTFS data run decoder.
// Holds register indexes, field widths and reset values; no dependencies.
package ndr_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_PART_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPC        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WANT       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd3;

  // Register widths
  localparam int unsigned PART_W   = 48;
  localparam int unsigned SPC_W    = 8;
  localparam int unsigned WANT_W   = 48;
  localparam int unsigned WINDOW_W = 24;
  localparam int unsigned LIMIT_W  = 49;
  localparam int unsigned ACC_W    = 64;

  // Register reset values
  localparam logic [SPC_W-1:0]    SPC_RESET    = 8'd8;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'h080000;

  // Bytes per sector is 512: a shift by nine
  localparam int unsigned SECTOR_SHIFT = 9;

  // Place one byte of a little-endian field; bytes past the eighth drop off
  function automatic logic [ACC_W-1:0] place_byte(input logic [7:0] b,
                                                  input logic [3:0] idx);
    logic [ACC_W-1:0] v;
    begin
      v = '0;
      if (!idx[3]) begin
        v = {56'd0, b} << {idx[2:0], 3'b000};
      end
      return v;
    end
  endfunction

endpackage

FILE: hdl/ntfs_data_run_decoder.sv
// NTFS mapping-pairs run list decoder, top level.
// Depends on ndr_pkg for register indexes, widths and the byte placement helper.
// Results: the byte that ends a run loads the pending stage, which moves to the output register when it can.
// Throughput: one byte per cycle; input stalls only while a result waits behind a stalled output.
// Reset: rst_n synchronous, active low; clears the parser and restores register defaults.
module ntfs_data_run_decoder import ndr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_run_byte,
  input  logic                  in_list_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           out_run_start_sector,
  output logic [63:0]           out_run_sector_count,
  output logic [63:0]           out_run_logical_byte,
  output logic                  out_reaches_want,
  output logic                  out_is_sparse,
  output logic                  out_end_of_list,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET,
    PH_DONE
  } phase_t;

  // Configuration registers
  logic [PART_W-1:0]   part_r;
  logic [SPC_W-1:0]    spc_r;
  logic [WANT_W-1:0]   want_r;
  logic [WINDOW_W-1:0] window_r;
  logic [LIMIT_W-1:0]  limit_r;

  // Parser state
  phase_t           phase_r, phase_nxt;
  logic [3:0]       len_size_r, len_size_nxt;
  logic [3:0]       off_size_r, off_size_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic [ACC_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] dlt_r, dlt_nxt;

  // Position state
  logic [ACC_W-1:0] sector_offset_r;
  logic [ACC_W-1:0] start_base_r;
  logic [ACC_W-1:0] logical_pos_r;

  // Pending stage between parser and output
  logic             p_valid_r;
  logic [ACC_W-1:0] p_sectors_r, p_sectors_nxt;
  logic [ACC_W-1:0] p_dsc_r, p_dsc_nxt;
  logic             p_sparse_r, p_sparse_nxt;
  logic             p_eol_r, p_eol_nxt;
  logic             p_load;

  // Output register
  logic             out_valid_r;
  logic [63:0]      out_start_r;
  logic [63:0]      out_count_r;
  logic [63:0]      out_logical_r;
  logic             out_reaches_r;
  logic             out_sparse_r;
  logic             out_eol_r;

  // Handshake and datapath signals
  logic             in_acc;
  logic             cfg_acc;
  logic             adv;
  logic [ACC_W-1:0] lpos_sum;
  logic [ACC_W-1:0] lpos_hdr;
  logic [ACC_W-1:0] start_sum;
  logic [ACC_W-1:0] offset_sum;
  phase_t           phase_eff;
  logic [3:0]       idx_inc;
  logic [ACC_W-1:0] cnt_new;
  logic [ACC_W-1:0] dlt_new;
  logic [ACC_W-1:0] dlt_fin;
  logic [ACC_W-1:0] mul_cnt;
  logic [ACC_W-1:0] mul_dlt;
  logic [71:0]      prod_cnt;
  logic [71:0]      prod_dlt;
  logic             fin;
  logic             fin_sparse;
  logic             eol_hit;

  // Handshakes: the pending stage moves on whenever the output can take it
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = p_valid_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Retire the pending run: advance logical position and sector offset
  assign lpos_sum   = logical_pos_r + {p_sectors_r[ACC_W-SECTOR_SHIFT-1:0],
                                       {SECTOR_SHIFT{1'b0}}};
  assign start_sum  = start_base_r + p_dsc_r;
  assign offset_sum = sector_offset_r + p_dsc_r;

  // Logical position seen by a header byte, including a run retiring now
  always_comb begin
    if (in_list_start) begin
      lpos_hdr = '0;
    end else if (p_valid_r) begin
      lpos_hdr = lpos_sum;
    end else begin
      lpos_hdr = logical_pos_r;
    end
  end

  // Field gathering
  assign phase_eff = in_list_start ? PH_HEADER : phase_r;
  assign idx_inc   = idx_r + 4'd1;
  assign cnt_new   = cnt_r | place_byte(in_run_byte, idx_r);
  assign dlt_new   = dlt_r | place_byte(in_run_byte, idx_r);

  // Sign-extend the delta from its last byte unless the offset is still zero
  always_comb begin
    dlt_fin = dlt_new;
    if (in_run_byte[7] && (sector_offset_r != '0) && !idx_inc[3]) begin
      dlt_fin = dlt_new | ({ACC_W{1'b1}} << {idx_inc[2:0], 3'b000});
    end
  end

  // Parser next state
  always_comb begin
    phase_nxt    = phase_r;
    len_size_nxt = len_size_r;
    off_size_nxt = off_size_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    dlt_nxt      = dlt_r;
    fin          = 1'b0;
    fin_sparse   = 1'b0;
    eol_hit      = 1'b0;
    mul_cnt      = cnt_r;
    mul_dlt      = dlt_fin;
    case (phase_eff)
      PH_HEADER: begin
        if ((in_run_byte == 8'd0) || ({15'd0, limit_r} <= lpos_hdr)) begin
          eol_hit   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          len_size_nxt = in_run_byte[3:0];
          off_size_nxt = in_run_byte[7:4];
          idx_nxt      = 4'd0;
          cnt_nxt      = '0;
          dlt_nxt      = '0;
          phase_nxt    = (in_run_byte[3:0] != 4'd0) ? PH_LENGTH : PH_OFFSET;
        end
      end
      PH_LENGTH: begin
        cnt_nxt = cnt_new;
        mul_cnt = cnt_new;
        if (idx_inc < len_size_r) begin
          idx_nxt = idx_inc;
        end else begin
          idx_nxt = 4'd0;
          if (off_size_r == 4'd0) begin
            fin        = 1'b1;
            fin_sparse = 1'b1;
            phase_nxt  = PH_HEADER;
          end else begin
            phase_nxt = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        dlt_nxt = dlt_new;
        if (idx_inc < off_size_r) begin
          idx_nxt = idx_inc;
        end else begin
          idx_nxt   = 4'd0;
          dlt_nxt   = dlt_fin;
          fin       = 1'b1;
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
  end

  // Scale clusters to sectors: one 64x8 product each, registered
  assign prod_cnt = 72'(mul_cnt) * 72'(spc_r);
  assign prod_dlt = 72'(mul_dlt) * 72'(spc_r);

  always_comb begin
    p_sectors_nxt = '0;
    p_dsc_nxt     = '0;
    p_sparse_nxt  = fin_sparse;
    p_eol_nxt     = eol_hit;
    if (fin) begin
      p_sectors_nxt = prod_cnt[ACC_W-1:0];
      if (!fin_sparse) begin
        p_dsc_nxt = prod_dlt[ACC_W-1:0];
      end
    end
  end

  assign p_load = adv || !p_valid_r;

  // Control, parser and position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r          <= '0;
      spc_r           <= SPC_RESET;
      want_r          <= '0;
      window_r        <= WINDOW_RESET;
      limit_r         <= LIMIT_W'(WINDOW_RESET);
      phase_r         <= PH_HEADER;
      len_size_r      <= '0;
      off_size_r      <= '0;
      idx_r           <= '0;
      cnt_r           <= '0;
      dlt_r           <= '0;
      sector_offset_r <= '0;
      start_base_r    <= '0;
      logical_pos_r   <= '0;
      p_valid_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      // Advance the parser
      if (in_acc) begin
        phase_r    <= phase_nxt;
        len_size_r <= len_size_nxt;
        off_size_r <= off_size_nxt;
        idx_r      <= idx_nxt;
        cnt_r      <= cnt_nxt;
        dlt_r      <= dlt_nxt;
      end

      // Retire the pending run, or clear positions at a new list
      if (in_acc && in_list_start) begin
        sector_offset_r <= '0;
        start_base_r    <= {{(ACC_W-PART_W){1'b0}}, part_r};
        logical_pos_r   <= '0;
      end else if (adv && p_valid_r) begin
        sector_offset_r <= offset_sum;
        start_base_r    <= start_sum;
        logical_pos_r   <= lpos_sum;
      end

      // Pending stage and output valid
      if (p_load) begin
        p_valid_r <= in_acc && (fin || eol_hit);
      end
      if (adv) begin
        out_valid_r <= p_valid_r;
      end

      // Configuration writes; derived sums follow the written register
      if (cfg_acc) begin
        case (cfg_index)
          CFG_PART_START: begin
            part_r       <= cfg_data[PART_W-1:0];
            start_base_r <= {{(ACC_W-PART_W){1'b0}}, cfg_data[PART_W-1:0]}
                            + sector_offset_r;
          end
          CFG_SPC: begin
            spc_r <= cfg_data[SPC_W-1:0];
          end
          CFG_WANT: begin
            want_r  <= cfg_data[WANT_W-1:0];
            limit_r <= LIMIT_W'(cfg_data[WANT_W-1:0]) + LIMIT_W'(window_r);
          end
          CFG_WINDOW: begin
            window_r <= cfg_data[WINDOW_W-1:0];
            limit_r  <= LIMIT_W'(want_r) + LIMIT_W'(cfg_data[WINDOW_W-1:0]);
          end
          default: begin
            spc_r <= spc_r;
          end
        endcase
      end
    end
  end

  // Pending and output payload
  always_ff @(posedge clk) begin
    if (p_load) begin
      p_sectors_r <= p_sectors_nxt;
      p_dsc_r     <= p_dsc_nxt;
      p_sparse_r  <= p_sparse_nxt;
      p_eol_r     <= p_eol_nxt;
    end
    if (adv && p_valid_r) begin
      if (p_eol_r) begin
        out_start_r   <= '0;
        out_count_r   <= '0;
        out_logical_r <= '0;
        out_reaches_r <= 1'b0;
        out_sparse_r  <= 1'b0;
        out_eol_r     <= 1'b1;
      end else begin
        out_start_r   <= start_sum;
        out_count_r   <= p_sectors_r;
        out_logical_r <= logical_pos_r;
        out_reaches_r <= lpos_sum > {{(ACC_W-WANT_W){1'b0}}, want_r};
        out_sparse_r  <= p_sparse_r;
        out_eol_r     <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_run_start_sector = out_start_r;
  assign out_run_sector_count = out_count_r;
  assign out_run_logical_byte = out_logical_r;
  assign out_reaches_want     = out_reaches_r;
  assign out_is_sparse        = out_sparse_r;
  assign out_end_of_list      = out_eol_r;

endmodule
